>>> rtl/core/acw_pkg.sv
// Shared types and constants for the ACK congestion window controller.
package acw_pkg;

	localparam int unsigned SEQ_W    = 32;
	localparam int unsigned MINW_W   = 11;
	localparam int unsigned WIN_W    = 14;
	localparam int unsigned RTT_W    = 16;
	localparam int unsigned TMO_W    = 17;
	localparam int unsigned DUP_W    = 2;
	localparam int unsigned PADDR_W  = 4;
	localparam int unsigned PDATA_W  = 32;

	// Register map, indexed by paddr[3:2]
	typedef enum logic [1:0] {
		REG_MIN_WINDOW   = 2'd0,
		REG_MAX_WINDOW   = 2'd1,
		REG_TOTAL_FRAMES = 2'd2
	} acw_reg_t;

	localparam logic [MINW_W-1:0] MIN_WINDOW_RST   = MINW_W'(32);
	localparam logic [WIN_W-1:0]  MAX_WINDOW_RST   = WIN_W'(1024);
	localparam logic [SEQ_W-1:0]  TOTAL_FRAMES_RST = '0;

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(32);
	localparam logic [RTT_W-1:0] RTT_RESET = RTT_W'(20);
	localparam logic [DUP_W-1:0] DUP_TRIGGER = DUP_W'(2);
	localparam logic [DUP_W-1:0] DUP_SAT     = DUP_W'(3);

	localparam logic [0:0] ACT_ACK     = 1'b0;
	localparam logic [0:0] ACT_TIMEOUT = 1'b1;

	// floor(x/5) == (x * RECIP5) >> RECIP5_SH for every x below 2^22
	localparam int unsigned RTT_SUM_W = RTT_W + 3;
	localparam int unsigned RECIP5_W  = 20;
	localparam int unsigned RECIP5_SH = 22;
	localparam logic [RECIP5_W-1:0] RECIP5 = RECIP5_W'(838861);

	typedef struct packed {
		logic [MINW_W-1:0] min_window;
		logic [WIN_W-1:0]  max_window;
		logic [SEQ_W-1:0]  total_frames;
	} acw_cfg_t;

	typedef struct packed {
		logic              action;
		logic [SEQ_W-1:0]  ack_number;
		logic              ack_flag_is_a;
		logic [RTT_W-1:0]  rtt_sample_ms;
	} acw_evt_t;

	typedef struct packed {
		logic [SEQ_W-1:0]  last_acked;
		logic [WIN_W-1:0]  window_size;
		logic              retransmit;
		logic [SEQ_W-1:0]  resend_seq;
		logic              rewind_sender;
		logic [RTT_W-1:0]  rtt_estimate_ms;
		logic [TMO_W-1:0]  timeout_ms;
		logic              in_recovery;
		logic              finished;
	} acw_res_t;

endpackage

>>> rtl/core/acw_evt_if.sv
// Event channel: one ACK or timeout word per handshake.
interface acw_evt_if;
	logic              valid;
	logic              ready;
	acw_pkg::acw_evt_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/acw_res_if.sv
// Result channel: one controller status word per handshake.
interface acw_res_if;
	logic              valid;
	logic              ready;
	acw_pkg::acw_res_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/acw_cfg.sv
// APB configuration registers: min_window, max_window, total_frames.
module acw_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [acw_pkg::PADDR_W-1:0]  paddr,
	input  logic [acw_pkg::PDATA_W-1:0]  pwdata,
	output logic [acw_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output acw_pkg::acw_cfg_t            cfg
);

	acw_pkg::acw_cfg_t cfg_q;
	acw_pkg::acw_reg_t reg_sel;
	logic              wr_en;

	assign pready  = 1'b1;
	assign reg_sel = acw_pkg::acw_reg_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_window   <= acw_pkg::MIN_WINDOW_RST;
			cfg_q.max_window   <= acw_pkg::MAX_WINDOW_RST;
			cfg_q.total_frames <= acw_pkg::TOTAL_FRAMES_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				acw_pkg::REG_MIN_WINDOW:   cfg_q.min_window   <= pwdata[acw_pkg::MINW_W-1:0];
				acw_pkg::REG_MAX_WINDOW:   cfg_q.max_window   <= pwdata[acw_pkg::WIN_W-1:0];
				acw_pkg::REG_TOTAL_FRAMES: cfg_q.total_frames <= pwdata[acw_pkg::SEQ_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			acw_pkg::REG_MIN_WINDOW:
				prdata = acw_pkg::PDATA_W'(cfg_q.min_window);
			acw_pkg::REG_MAX_WINDOW:
				prdata = acw_pkg::PDATA_W'(cfg_q.max_window);
			acw_pkg::REG_TOTAL_FRAMES:
				prdata = acw_pkg::PDATA_W'(cfg_q.total_frames);
			default:
				prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/acw_state.sv
// Congestion state registers and the combinational update for one event.
module acw_state (
	input  logic              clk,
	input  logic              arst_n,
	input  acw_pkg::acw_cfg_t cfg,
	input  logic              upd_en,
	input  acw_pkg::acw_evt_t evt,
	output acw_pkg::acw_res_t res_next
);

	logic [acw_pkg::SEQ_W-1:0] acked_q,  acked_d;
	logic [acw_pkg::DUP_W-1:0] dup_q,    dup_d;
	logic [acw_pkg::WIN_W-1:0] window_q, window_d;
	logic                      additive_q, additive_d;
	logic [acw_pkg::RTT_W-1:0] rtt_q,    rtt_d;
	logic                      recovering_q, recovering_d;
	logic                      done_q,   done_d;
	logic                      retx, rewind;

	logic [acw_pkg::WIN_W-1:0]     eff_min, eff_max, half;
	logic [acw_pkg::WIN_W:0]       grown;
	logic [acw_pkg::DUP_W-1:0]     dup_inc;
	logic [acw_pkg::RTT_SUM_W-1:0] rtt_sum;
	logic [acw_pkg::RTT_SUM_W+acw_pkg::RECIP5_W-1:0] rtt_prod;
	logic [acw_pkg::RTT_W-1:0]     rtt_new;
	logic [acw_pkg::SEQ_W-1:0]     ack_gap;
	logic                          ack_ahead;

	assign eff_min = (cfg.min_window == '0) ? acw_pkg::WIN_W'(1)
	                                        : acw_pkg::WIN_W'(cfg.min_window);
	assign eff_max = (cfg.max_window == '0) ? acw_pkg::WIN_W'(1) : cfg.max_window;
	assign half    = window_q >> 1;
	assign grown   = additive_q ? ({1'b0, window_q} + (acw_pkg::WIN_W+1)'(1))
	                            : {window_q, 1'b0};
	assign ack_ahead = evt.ack_number > acked_q;
	assign ack_gap   = evt.ack_number - acked_q;

	// (sample + 4*rtt) / 5 through a reciprocal multiply
	assign rtt_sum  = acw_pkg::RTT_SUM_W'(evt.rtt_sample_ms) + {1'b0, rtt_q, 2'b00};
	assign rtt_prod = rtt_sum * acw_pkg::RECIP5;
	assign rtt_new  = rtt_prod[acw_pkg::RECIP5_SH +: acw_pkg::RTT_W];

	assign dup_inc = (evt.ack_number == acked_q && dup_q < acw_pkg::DUP_SAT)
	               ? dup_q + acw_pkg::DUP_W'(1) : dup_q;

	always_comb begin
		acked_d      = acked_q;
		dup_d        = dup_q;
		window_d     = window_q;
		additive_d   = additive_q;
		rtt_d        = rtt_q;
		recovering_d = recovering_q;
		done_d       = done_q;
		retx         = 1'b0;
		rewind       = 1'b0;
		if (!done_q) begin
			if (evt.action == acw_pkg::ACT_TIMEOUT) begin
				if (recovering_q) begin
					retx = 1'b1;
				end else begin
					rewind     = 1'b1;
					window_d   = eff_min;
					additive_d = 1'b0;
				end
			end else begin
				if (recovering_q) begin
					// leave recovery: halve, floor at min, go additive
					if (ack_ahead) begin
						dup_d        = '0;
						recovering_d = 1'b0;
						acked_d      = evt.ack_number;
						window_d     = (half < eff_min) ? eff_min : half;
						additive_d   = 1'b1;
					end
				end else begin
					dup_d = dup_inc;
					if (dup_inc == acw_pkg::DUP_TRIGGER) begin
						recovering_d = 1'b1;
						retx         = 1'b1;
					end else if (ack_ahead) begin
						if (ack_gap == acw_pkg::SEQ_W'(1) && evt.ack_flag_is_a) begin
							rtt_d    = rtt_new;
							window_d = (grown > {1'b0, eff_max}) ? eff_max
							                                     : grown[acw_pkg::WIN_W-1:0];
						end
						acked_d = evt.ack_number;
					end
				end
				if (acked_d == cfg.total_frames) begin
					done_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acked_q      <= '0;
			dup_q        <= '0;
			window_q     <= acw_pkg::WIN_RESET;
			additive_q   <= 1'b0;
			rtt_q        <= acw_pkg::RTT_RESET;
			recovering_q <= 1'b0;
			done_q       <= 1'b0;
		end else if (upd_en) begin
			acked_q      <= acked_d;
			dup_q        <= dup_d;
			window_q     <= window_d;
			additive_q   <= additive_d;
			rtt_q        <= rtt_d;
			recovering_q <= recovering_d;
			done_q       <= done_d;
		end
	end

	always_comb begin
		res_next.last_acked      = acked_d;
		res_next.window_size     = window_d;
		res_next.retransmit      = retx;
		res_next.resend_seq      = acked_d + acw_pkg::SEQ_W'(1);
		res_next.rewind_sender   = rewind;
		res_next.rtt_estimate_ms = rtt_d;
		res_next.timeout_ms      = {rtt_d, 1'b0};
		res_next.in_recovery     = recovering_d;
		res_next.finished        = done_d;
	end

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> done_q) else $error("finished flag dropped");

	a_recovery_dup: assert property (@(posedge clk) disable iff (!arst_n)
		recovering_q |-> dup_q == acw_pkg::DUP_TRIGGER)
		else $error("in recovery without duplicate trigger count");

	a_window_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		window_q != '0) else $error("window reached zero");

endmodule

>>> rtl/core/ack_congestion_window_controller.sv
// Top level: event input stage, congestion update, result register, APB registers.
//
//  channel | dir | handshake     | word
//  evt     | in  | valid/ready   | action, ack_number, ack_flag_is_a, rtt_sample_ms
//  res     | out | valid/ready   | last_acked ... finished, one word per event
//  apb     | in  | psel/penable  | min_window, max_window, total_frames at 0x0/0x4/0x8
//
// An event is held in the input stage (evt_s1) and its result is registered in the
// result register (res_s2); one event per cycle while res.ready stays high.
// The update is combinational because state feeds straight back into the next event.
// Reset clears the state to its defaults and empties both stages.
// A stalled result holds the input stage; evt.ready falls only when both are full.
module ack_congestion_window_controller (
	input  logic                         clk,
	input  logic                         arst_n,
	acw_evt_if.sink                      evt,
	acw_res_if.source                    res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [acw_pkg::PADDR_W-1:0]  paddr,
	input  logic [acw_pkg::PDATA_W-1:0]  pwdata,
	output logic [acw_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	acw_pkg::acw_cfg_t cfg;
	acw_pkg::acw_evt_t evt_s1;
	logic              valid_s1;
	acw_pkg::acw_res_t res_s2;
	acw_pkg::acw_res_t res_next;
	logic              valid_s2;
	logic              advance;
	logic              upd_en;

	// result register free, or being drained this cycle
	assign advance   = !valid_s2 || res.ready;
	assign upd_en    = valid_s1 && advance;
	assign evt.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			evt_s1 <= evt.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_en) begin
			res_s2 <= res_next;
		end
	end

	assign res.valid = valid_s2;
	assign res.data  = res_s2;

	acw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	acw_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.upd_en   (upd_en),
		.evt      (evt_s1),
		.res_next (res_next)
	);

	a_retx_rewind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.retransmit && res_s2.rewind_sender))
		else $error("retransmit and rewind in the same result");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> evt.ready) else $error("input stalled with empty result register");

	a_rewind_not_recovering: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.rewind_sender) |-> !res_s2.in_recovery)
		else $error("rewind reported while in recovery");

endmodule

>>> bench/tb_ack_congestion_window_controller.sv
// Self-checking bench for the ACK congestion window controller: events in, status words out.
module tb_ack_congestion_window_controller;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned PHASE_ITEMS = 310;
	localparam int unsigned NUM_PHASES  = 6;

	class cwnd_scoreboard;
		logic [acw_pkg::SEQ_W-1:0] acked_seq;
		int unsigned               dup_count;
		int unsigned               window;
		bit                        additive_mode;
		int unsigned               smoothed_rtt;
		bit                        recovering;
		bit                        done;
		int unsigned               min_window;
		int unsigned               max_window;
		logic [acw_pkg::SEQ_W-1:0] total_frames;
		acw_pkg::acw_res_t         status_due[$];
		int unsigned               failures;

		function new();
			acked_seq     = '0;
			dup_count     = 0;
			window        = 32'(acw_pkg::WIN_RESET);
			additive_mode = 1'b0;
			smoothed_rtt  = 32'(acw_pkg::RTT_RESET);
			recovering    = 1'b0;
			done          = 1'b0;
			min_window    = 32'(acw_pkg::MIN_WINDOW_RST);
			max_window    = 32'(acw_pkg::MAX_WINDOW_RST);
			total_frames  = acw_pkg::TOTAL_FRAMES_RST;
			failures      = 0;
		endfunction

		function void write_reg(acw_pkg::acw_reg_t idx, logic [acw_pkg::PDATA_W-1:0] value);
			case (idx)
				acw_pkg::REG_MIN_WINDOW:   min_window = 32'(value[acw_pkg::MINW_W-1:0]);
				acw_pkg::REG_MAX_WINDOW:   max_window = 32'(value[acw_pkg::WIN_W-1:0]);
				acw_pkg::REG_TOTAL_FRAMES: total_frames = value[acw_pkg::SEQ_W-1:0];
				default:          ;
			endcase
		endfunction

		// Advance the window state by one event and queue the status word it produces.
		function void note_event(acw_pkg::acw_evt_t e);
			acw_pkg::acw_res_t r;
			bit                retx;
			bit                rewind;
			int unsigned       lo;
			int unsigned       hi;
			int unsigned       half;
			int unsigned       grown;
			retx   = 1'b0;
			rewind = 1'b0;
			lo = (min_window == 0) ? 1 : min_window;
			hi = (max_window == 0) ? 1 : max_window;
			if (!done) begin
				if (e.action == acw_pkg::ACT_TIMEOUT) begin
					if (recovering) begin
						retx = 1'b1;
					end else begin
						rewind        = 1'b1;
						window        = lo;
						additive_mode = 1'b0;
					end
				end else begin
					if (recovering) begin
						if (e.ack_number > acked_seq) begin
							half          = window >> 1;
							dup_count     = 0;
							recovering    = 1'b0;
							acked_seq     = e.ack_number;
							window        = (half < lo) ? lo : half;
							additive_mode = 1'b1;
						end
					end else begin
						if (e.ack_number == acked_seq && dup_count < 32'(acw_pkg::DUP_SAT))
							dup_count++;
						if (dup_count == 32'(acw_pkg::DUP_TRIGGER)) begin
							recovering = 1'b1;
							retx       = 1'b1;
						end else if (e.ack_number > acked_seq) begin
							if (e.ack_number - acked_seq == 32'd1 && e.ack_flag_is_a) begin
								smoothed_rtt = (32'(e.rtt_sample_ms) + 4 * smoothed_rtt) / 5;
								grown = additive_mode ? window + 1 : window * 2;
								if (grown > hi)
									grown = hi;
								window = grown;
							end
							acked_seq = e.ack_number;
						end
					end
					if (acked_seq == total_frames)
						done = 1'b1;
				end
			end
			r.last_acked      = acked_seq;
			r.window_size     = acw_pkg::WIN_W'(window);
			r.retransmit      = retx;
			r.resend_seq      = acked_seq + 32'd1;
			r.rewind_sender   = rewind;
			r.rtt_estimate_ms = acw_pkg::RTT_W'(smoothed_rtt);
			r.timeout_ms      = acw_pkg::TMO_W'(2 * smoothed_rtt);
			r.in_recovery     = recovering;
			r.finished        = done;
			status_due.push_back(r);
		endfunction

		function void flag_error(string what, logic [63:0] want, logic [63:0] got);
			failures++;
			if (failures <= 10)
				$display("mismatch %s: expected %0h, got %0h", what, want, got);
		endfunction

		function void check_status(acw_pkg::acw_res_t got);
			acw_pkg::acw_res_t want;
			if (status_due.size() == 0) begin
				flag_error("unexpected word, last_acked", '0, 64'(got.last_acked));
				return;
			end
			want = status_due.pop_front();
			if (got.last_acked !== want.last_acked)
				flag_error("last_acked", 64'(want.last_acked), 64'(got.last_acked));
			if (got.window_size !== want.window_size)
				flag_error("window_size", 64'(want.window_size), 64'(got.window_size));
			if (got.retransmit !== want.retransmit)
				flag_error("retransmit", 64'(want.retransmit), 64'(got.retransmit));
			if (got.resend_seq !== want.resend_seq)
				flag_error("resend_seq", 64'(want.resend_seq), 64'(got.resend_seq));
			if (got.rewind_sender !== want.rewind_sender)
				flag_error("rewind_sender", 64'(want.rewind_sender), 64'(got.rewind_sender));
			if (got.rtt_estimate_ms !== want.rtt_estimate_ms)
				flag_error("rtt_estimate_ms", 64'(want.rtt_estimate_ms),
					64'(got.rtt_estimate_ms));
			if (got.timeout_ms !== want.timeout_ms)
				flag_error("timeout_ms", 64'(want.timeout_ms), 64'(got.timeout_ms));
			if (got.in_recovery !== want.in_recovery)
				flag_error("in_recovery", 64'(want.in_recovery), 64'(got.in_recovery));
			if (got.finished !== want.finished)
				flag_error("finished", 64'(want.finished), 64'(got.finished));
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [acw_pkg::PADDR_W-1:0] paddr;
	logic [acw_pkg::PDATA_W-1:0] pwdata;
	logic [acw_pkg::PDATA_W-1:0] prdata;
	logic                        pready;

	acw_evt_if evt_ch ();
	acw_res_if res_ch ();

	cwnd_scoreboard board = new();
	int unsigned    cycle_count;
	int unsigned    events_sent;
	int unsigned    stall_left;
	bit             src_calm;
	bit             snk_calm;

	ack_congestion_window_controller u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.evt     (evt_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned rand_sample();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 200);
		else if (r < 90)
			return $urandom_range(0, 2000);
		return $urandom_range(0, 65535);
	endfunction

	function automatic bit rand_bit();
		return $urandom_range(0, 1) != 0;
	endfunction

	function automatic acw_pkg::acw_evt_t ack_word(logic [acw_pkg::SEQ_W-1:0] n, bit flag_a,
		int unsigned s);
		acw_pkg::acw_evt_t e;
		e.action        = acw_pkg::ACT_ACK;
		e.ack_number    = n;
		e.ack_flag_is_a = flag_a;
		e.rtt_sample_ms = acw_pkg::RTT_W'(s);
		return e;
	endfunction

	// Timeout words carry random leftovers in the ACK fields.
	function automatic acw_pkg::acw_evt_t timeout_word();
		acw_pkg::acw_evt_t e;
		e.action        = acw_pkg::ACT_TIMEOUT;
		e.ack_number    = $urandom;
		e.ack_flag_is_a = rand_bit();
		e.rtt_sample_ms = acw_pkg::RTT_W'($urandom_range(0, 65535));
		return e;
	endfunction

	// Result side: random stalls, sampled at the rising edge.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			res_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			res_ch.ready <= 1'b1;
			if (!snk_calm && $urandom_range(0, 99) < 25)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			board.check_status(res_ch.data);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_event(input acw_pkg::acw_evt_t e);
		int unsigned gap;
		gap = (src_calm || $urandom_range(0, 99) < 60) ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			evt_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.data  <= e;
		do @(posedge clk); while (!evt_ch.ready);
		board.note_event(e);
		events_sent++;
	endtask

	// Hold the sender until every status word has come back.
	task automatic drain_results();
		@(negedge clk);
		evt_ch.valid <= 1'b0;
		while (board.status_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input acw_pkg::acw_reg_t idx,
		input logic [acw_pkg::PDATA_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= acw_pkg::PADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.write_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic run_directed();
		drain_results();
		write_reg(acw_pkg::REG_MIN_WINDOW, 4);
		write_reg(acw_pkg::REG_MAX_WINDOW, 64);
		write_reg(acw_pkg::REG_TOTAL_FRAMES, '1);
		send_event(ack_word(1, 1'b1, 0));
		send_event(ack_word(2, 1'b1, 65535));
		send_event(ack_word(3, 1'b0, 100));
		send_event(ack_word(10, 1'b1, 50));
		send_event(ack_word(5, 1'b1, 50));
		send_event(timeout_word());
		// two duplicates: fast retransmit and recovery
		send_event(ack_word(10, 1'b1, 30));
		send_event(ack_word(10, 1'b0, 30));
		send_event(ack_word(10, 1'b1, 30));
		send_event(timeout_word());
		send_event(ack_word(12, 1'b1, 30));
		send_event(ack_word(13, 1'b1, 30));
		send_event(ack_word(14, 1'b1, 30));
		drain_results();
		// zero window registers act as one
		write_reg(acw_pkg::REG_MIN_WINDOW, 0);
		write_reg(acw_pkg::REG_MAX_WINDOW, 0);
		send_event(timeout_word());
		send_event(ack_word(15, 1'b1, 20));
		drain_results();
		write_reg(acw_pkg::REG_MIN_WINDOW, 1024);
		write_reg(acw_pkg::REG_MAX_WINDOW, 16383);
		send_event(timeout_word());
		for (int i = 16; i < 20; i++)
			send_event(ack_word(i, 1'b1, 10));
		drain_results();
		// minimum above maximum
		write_reg(acw_pkg::REG_MAX_WINDOW, 1);
		send_event(timeout_word());
		send_event(ack_word(20, 1'b1, 10));
		drain_results();
	endtask

	task automatic run_random(input int unsigned count);
		int unsigned               target;
		int unsigned               r;
		int unsigned               tries;
		logic [acw_pkg::SEQ_W-1:0] cur;
		target = events_sent + count;
		while (events_sent < target) begin
			if ($urandom_range(0, 99) < 5)
				src_calm = !src_calm;
			if ($urandom_range(0, 99) < 5)
				snk_calm = !snk_calm;
			if ($urandom_range(0, 199) == 0)
				drain_results();
			cur = board.acked_seq;
			r = $urandom_range(0, 99);
			if (r < 45) begin
				repeat ($urandom_range(1, 8))
					send_event(ack_word(board.acked_seq + 32'd1,
						$urandom_range(0, 9) != 0, rand_sample()));
			end else if (r < 60) begin
				// loss episode: duplicates, noise while recovering, then a new ACK
				tries = 0;
				while (!board.recovering && tries < 3) begin
					send_event(ack_word(board.acked_seq, rand_bit(), rand_sample()));
					tries++;
				end
				repeat ($urandom_range(0, 2)) begin
					if ($urandom_range(0, 1))
						send_event(timeout_word());
					else
						send_event(ack_word($urandom_range(0, board.acked_seq),
							rand_bit(), rand_sample()));
				end
				send_event(ack_word(board.acked_seq + $urandom_range(1, 20),
					rand_bit(), rand_sample()));
			end else if (r < 70) begin
				send_event(timeout_word());
			end else if (r < 78) begin
				send_event(ack_word(cur + $urandom_range(2, 100), rand_bit(),
					rand_sample()));
			end else if (r < 86) begin
				send_event(ack_word((cur == 0) ? '0 : $urandom_range(0, cur - 1),
					rand_bit(), rand_sample()));
			end else begin
				send_event(ack_word(cur, rand_bit(), rand_sample()));
			end
		end
	endtask

	task automatic set_phase(input int unsigned p);
		logic [acw_pkg::SEQ_W-1:0] cur;
		drain_results();
		cur = board.acked_seq;
		case (p)
			0: begin
				write_reg(acw_pkg::REG_MIN_WINDOW, 32);
				write_reg(acw_pkg::REG_MAX_WINDOW, 1024);
			end
			1: begin
				write_reg(acw_pkg::REG_MIN_WINDOW, 1);
				write_reg(acw_pkg::REG_MAX_WINDOW, 16383);
			end
			3: begin
				write_reg(acw_pkg::REG_MIN_WINDOW, 0);
				write_reg(acw_pkg::REG_MAX_WINDOW, $urandom_range(1, 300));
			end
			4: begin
				write_reg(acw_pkg::REG_MIN_WINDOW, 1023);
				write_reg(acw_pkg::REG_MAX_WINDOW, 2);
			end
			default: begin
				write_reg(acw_pkg::REG_MIN_WINDOW, $urandom_range(1, 1024));
				write_reg(acw_pkg::REG_MAX_WINDOW, $urandom_range(1, 16383));
			end
		endcase
		// keep the finish point behind the current ACK so it is never reached
		write_reg(acw_pkg::REG_TOTAL_FRAMES,
			(p == 1 || cur == 0) ? '0 : $urandom_range(0, cur - 1));
		src_calm = rand_bit();
		snk_calm = rand_bit();
		// jump the sequence space upward
		if (p == 3)
			send_event(ack_word(32'h8000_0000 + $urandom_range(0, 32'h3FFF_FFFF), 1'b1,
				rand_sample()));
		else if (p == 5)
			send_event(ack_word(32'hE000_0000 + $urandom_range(0, 32'h0FFF_FFFF), 1'b0,
				rand_sample()));
	endtask

	task automatic run_finish();
		drain_results();
		write_reg(acw_pkg::REG_TOTAL_FRAMES, '1);
		send_event(ack_word(32'hFFFF_FFFE, 1'b1, 40));
		send_event(ack_word(32'hFFFF_FFFF, 1'b1, 65535));
		// frozen once finished
		send_event(timeout_word());
		send_event(ack_word(0, 1'b1, 5));
		send_event(ack_word(32'hFFFF_FFFF, 1'b1, 5));
	endtask

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		evt_ch.valid   = 1'b0;
		evt_ch.data    = '0;
		res_ch.ready   = 1'b0;
		cycle_count    = 0;
		events_sent    = 0;
		stall_left     = 0;
		src_calm       = 1'b0;
		snk_calm       = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		run_directed();
		for (int unsigned p = 0; p < NUM_PHASES; p++) begin
			set_phase(p);
			run_random(PHASE_ITEMS);
		end
		run_finish();
		drain_results();
		repeat (8) @(posedge clk);
		if (board.failures == 0 && board.status_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
